// ===== rtl/core/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// shared constants, codes and types of the tile membership set
// ----------------------------------------------------------------------------
`default_nettype none

package tms_pkg;

    localparam int CAPACITY    = 4096;
    localparam int ZOOM_LEVELS = 17;
    localparam int AW          = $clog2(CAPACITY);
    localparam int CW          = AW + 1;
    localparam int ZW          = 5;
    localparam int KW          = 32;
    localparam int EW          = ZW + KW;
    localparam int TCW         = 13;
    localparam int ZIW         = (ZOOM_LEVELS > 1) ? $clog2(ZOOM_LEVELS) : 1;
    localparam int CFGW        = 5;
    localparam int CIW         = 1;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_FINAL = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_UNSORTED = 2'd3
    } t_status;

    typedef logic [EW-1:0] t_entry;

    localparam logic [CIW-1:0] REG_LOWEST  = 1'b0;
    localparam logic [CIW-1:0] REG_HIGHEST = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/tile_membership_set_core.sv =====
// ----------------------------------------------------------------------------
// tile_membership_set_core
// per-zoom tile set with append, merge sort plus dedupe, and binary search
// ----------------------------------------------------------------------------
// An item is taken when i_start is high and o_busy is low; its result shows on
// o_done for one cycle and cannot be held off. An add, a no-op and any
// rejected item answer in the cycle after acceptance and keep o_busy low. A
// query first sums the zoom counts below its zoom and then does a binary
// search, reading each probe in S_SRCH and comparing it in S_SCMP, through
// the single read port of the store. A finalize runs a bottom-up merge sort
// between two ping-pong store memories in about log2(n) segment passes, then
// one dedupe and recount pass. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_membership_set_core
    import tms_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [1:0]        i_func,
    input  wire logic [ZW-1:0]     i_zoom,
    input  wire logic [15:0]       i_tile_x,
    input  wire logic [15:0]       i_tile_y,
    input  wire logic              i_cfg_we,
    input  wire logic [CIW-1:0]    i_cfg_idx,
    input  wire logic [CFGW-1:0]   i_cfg_data,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic                   o_hit,
    output logic [TCW-1:0]         o_total_count
);

    typedef enum logic [3:0] {
        S_IDLE, S_BASE, S_SRCH, S_SCMP, S_MPASS, S_MSEG, S_MLDI, S_MLDJ,
        S_MLDW, S_MEMIT, S_MWAIT, S_DDRD, S_DDCHK
    } t_state;

    t_state          r_state;
    logic [ZW-1:0]   r_lowest, r_highest;
    logic [CW-1:0]   r_fill;
    logic            r_sorted;
    logic            r_bank;
    logic [CW-1:0]   r_cnt [ZOOM_LEVELS];
    t_entry          r_entry;
    logic [ZW-1:0]   r_zoom;
    logic [ZW-1:0]   r_zi;
    logic [CW-1:0]   r_w, r_lo, r_mid, r_hi, r_i, r_j, r_k;
    logic [CW-1:0]   r_rd, r_wr;
    t_entry          r_head_i, r_head_j, r_last;
    logic            r_take_j;
    logic            r_done;
    t_status         r_status;
    logic            r_hit;

    t_entry          mem0 [CAPACITY];
    t_entry          mem1 [CAPACITY];
    t_entry          r_q0, r_q1;

    logic            n_we;
    logic            n_wsel;
    logic [AW-1:0]   n_waddr;
    t_entry          n_wdata;
    logic [AW-1:0]   n_raddr;

    t_entry          q;
    t_entry          entry_in;
    logic            zoom_ok;
    logic            add_ok;
    logic [CW:0]     sum_lw, sum_mw, hi_sum;
    logic [CW-1:0]   seg_mid, seg_hi, srch_hi, smid;
    logic            take_j;
    logic [CW-1:0]   cnt_sel;
    logic            dd_new;
    logic [CW-1:0]   wr_next;
    logic [CW:0]     rd_next;
    t_func           func;

    assign func     = t_func'(i_func);
    assign q        = r_bank ? r_q1 : r_q0;
    assign entry_in = {i_zoom, i_tile_x, i_tile_y};
    assign zoom_ok  = (i_zoom >= r_lowest) && (i_zoom <= r_highest)
                   && (i_zoom < ZW'(ZOOM_LEVELS));
    assign add_ok   = zoom_ok && (r_fill < CW'(CAPACITY));

    assign sum_lw  = {1'b0, r_lo} + {1'b0, r_w};
    assign seg_mid = (sum_lw > {1'b0, r_fill}) ? r_fill : sum_lw[CW-1:0];
    assign sum_mw  = {1'b0, seg_mid} + {1'b0, r_w};
    assign seg_hi  = (sum_mw > {1'b0, r_fill}) ? r_fill : sum_mw[CW-1:0];

    assign take_j  = (r_j < r_hi) && ((r_i >= r_mid) || (r_head_j < r_head_i));

    assign cnt_sel = r_cnt[r_zi[ZIW-1:0]];
    assign hi_sum  = {1'b0, r_k} + {1'b0, cnt_sel};
    assign srch_hi = (hi_sum > {1'b0, r_fill}) ? r_fill : hi_sum[CW-1:0];
    assign smid    = r_lo + ((r_hi - r_lo) >> 1);

    assign dd_new  = (r_rd == '0) || (q != r_last);
    assign wr_next = r_wr + CW'(dd_new);
    assign rd_next = {1'b0, r_rd} + 1'b1;

    // memory port control
    always_comb begin
        n_we    = 1'b0;
        n_wsel  = r_bank;
        n_waddr = '0;
        n_wdata = entry_in;
        n_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && func == FUNC_ADD && add_ok) begin
                    n_we    = 1'b1;
                    n_waddr = r_fill[AW-1:0];
                end
            end
            S_SRCH:  n_raddr = smid[AW-1:0];
            S_MLDI:  n_raddr = r_i[AW-1:0];
            S_MLDJ:  n_raddr = r_j[AW-1:0];
            S_MEMIT: begin
                n_raddr = take_j ? AW'(r_j + 1'b1) : AW'(r_i + 1'b1);
                if (r_k < r_hi) begin
                    n_we    = 1'b1;
                    n_wsel  = ~r_bank;
                    n_waddr = r_k[AW-1:0];
                    n_wdata = take_j ? r_head_j : r_head_i;
                end
            end
            S_DDRD:  n_raddr = r_rd[AW-1:0];
            S_DDCHK: begin
                if (dd_new) begin
                    n_we    = 1'b1;
                    n_waddr = r_wr[AW-1:0];
                    n_wdata = q;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we && !n_wsel) mem0[n_waddr] <= n_wdata;
        r_q0 <= mem0[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (n_we && n_wsel) mem1[n_waddr] <= n_wdata;
        r_q1 <= mem1[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lowest  <= '0;
            r_highest <= ZW'(16);
            r_fill    <= '0;
            r_sorted  <= 1'b0;
            r_bank    <= 1'b0;
            r_done    <= 1'b0;
            r_status  <= ST_OK;
            r_hit     <= 1'b0;
            for (int z = 0; z < ZOOM_LEVELS; z++) begin
                r_cnt[z] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_LOWEST) r_lowest <= i_cfg_data;
                if (i_cfg_idx == REG_HIGHEST) r_highest <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_entry <= entry_in;
                        r_zoom  <= i_zoom;
                        r_hit   <= 1'b0;
                        r_status <= ST_OK;
                        case (func)
                            FUNC_ADD: begin
                                r_done <= 1'b1;
                                if (!zoom_ok) begin
                                    r_status <= ST_RANGE;
                                end else if (!add_ok) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_fill   <= r_fill + 1'b1;
                                    r_sorted <= 1'b0;
                                    r_cnt[i_zoom[ZIW-1:0]] <=
                                        r_cnt[i_zoom[ZIW-1:0]] + 1'b1;
                                end
                            end
                            FUNC_FINAL: begin
                                r_w     <= CW'(1);
                                r_state <= S_MPASS;
                            end
                            FUNC_QUERY: begin
                                if (!r_sorted) begin
                                    r_status <= ST_UNSORTED;
                                    r_done   <= 1'b1;
                                end else if (!zoom_ok) begin
                                    r_status <= ST_RANGE;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_zi    <= '0;
                                    r_k     <= '0;
                                    r_state <= S_BASE;
                                end
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                // prefix sum of lower zoom counts
                S_BASE: begin
                    if (r_zi == r_zoom) begin
                        r_lo    <= r_k;
                        r_hi    <= srch_hi;
                        r_state <= S_SRCH;
                    end else begin
                        r_k  <= hi_sum[CW-1:0];
                        r_zi <= r_zi + 1'b1;
                    end
                end
                S_SRCH: begin
                    if (r_lo >= r_hi) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_mid   <= smid;
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (q == r_entry) begin
                        r_hit   <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        if (q < r_entry) r_lo <= r_mid + 1'b1;
                        else r_hi <= r_mid;
                        r_state <= S_SRCH;
                    end
                end
                // merge sort passes
                S_MPASS: begin
                    if (r_w >= r_fill) begin
                        r_rd <= '0;
                        r_wr <= '0;
                        for (int z = 0; z < ZOOM_LEVELS; z++) begin
                            r_cnt[z] <= '0;
                        end
                        if (r_fill == '0) begin
                            r_sorted <= 1'b1;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_DDRD;
                        end
                    end else begin
                        r_lo    <= '0;
                        r_state <= S_MSEG;
                    end
                end
                S_MSEG: begin
                    if (r_lo >= r_fill) begin
                        r_bank  <= ~r_bank;
                        r_w     <= r_w << 1;
                        r_state <= S_MPASS;
                    end else begin
                        r_mid   <= seg_mid;
                        r_hi    <= seg_hi;
                        r_i     <= r_lo;
                        r_j     <= seg_mid;
                        r_k     <= r_lo;
                        r_state <= S_MLDI;
                    end
                end
                S_MLDI: r_state <= S_MLDJ;
                S_MLDJ: begin
                    r_head_i <= q;
                    r_state  <= S_MLDW;
                end
                S_MLDW: begin
                    r_head_j <= q;
                    r_state  <= S_MEMIT;
                end
                S_MEMIT: begin
                    if (r_k >= r_hi) begin
                        r_lo    <= r_hi;
                        r_state <= S_MSEG;
                    end else begin
                        r_k      <= r_k + 1'b1;
                        r_take_j <= take_j;
                        if (take_j) r_j <= r_j + 1'b1;
                        else r_i <= r_i + 1'b1;
                        r_state <= S_MWAIT;
                    end
                end
                S_MWAIT: begin
                    if (r_take_j) r_head_j <= q;
                    else r_head_i <= q;
                    r_state <= S_MEMIT;
                end
                // dedupe and recount
                S_DDRD: r_state <= S_DDCHK;
                S_DDCHK: begin
                    if (dd_new) begin
                        r_last <= q;
                        if (q[EW-1:KW] < ZW'(ZOOM_LEVELS)) begin
                            r_cnt[q[KW+ZIW-1:KW]] <= r_cnt[q[KW+ZIW-1:KW]] + 1'b1;
                        end
                    end
                    r_wr <= wr_next;
                    if (rd_next >= {1'b0, r_fill}) begin
                        r_fill   <= wr_next;
                        r_sorted <= 1'b1;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_rd    <= rd_next[CW-1:0];
                        r_state <= S_DDRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_hit         = r_hit;
    assign o_total_count = TCW'(r_fill);

endmodule

`default_nettype wire
